@@ sv/mpa_pkg.sv @@
// Package: sizes, state type and scan structs for the min/max pop accumulator.
`timescale 1ns / 1ps
package mpa_pkg;

  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 20;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int GAIN_W     = 20;
  localparam int TOTAL_W    = 48;
  localparam int BILL_W     = 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WR_HI,
    ST_WR_LO,
    ST_RES
  } mpa_state_t;

  typedef struct packed {
    logic              issue;
    logic [ADDR_W-1:0] idx;
  } mpa_scan_req_t;

  typedef struct packed {
    logic                  done;
    logic [ADDR_W-1:0]     imin;
    logic [ADDR_W-1:0]     imax;
    logic [VALUE_BITS-1:0] vmin;
    logic [VALUE_BITS-1:0] vmax;
    logic [VALUE_BITS-1:0] vlast;
    logic [VALUE_BITS-1:0] vsec;
  } mpa_scan_res_t;

endpackage

@@ sv/mpa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mpa_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 20,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/mpa_scan.sv @@
// Scan tracker: follows RAM read data and records min, max and tail entries.
`timescale 1ns / 1ps
module mpa_scan import mpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mpa_scan_req_t         req,
  input  logic [VALUE_BITS-1:0] rd_data,
  input  logic [ADDR_W-1:0]     last_idx,
  output mpa_scan_res_t         res
);

  logic                  vld_d_r, vld_d_nxt;
  logic [ADDR_W-1:0]     idx_d_r, idx_d_nxt;
  logic [ADDR_W-1:0]     imin_r, imin_nxt;
  logic [ADDR_W-1:0]     imax_r, imax_nxt;
  logic [VALUE_BITS-1:0] vmin_r, vmin_nxt;
  logic [VALUE_BITS-1:0] vmax_r, vmax_nxt;
  logic [VALUE_BITS-1:0] vlast_r, vlast_nxt;
  logic [VALUE_BITS-1:0] vsec_r, vsec_nxt;
  logic [ADDR_W-1:0]     sec_idx;

  assign sec_idx = last_idx - ADDR_W'(1);

  always_comb begin
    vld_d_nxt = req.issue;
    idx_d_nxt = req.idx;
    imin_nxt  = imin_r;
    imax_nxt  = imax_r;
    vmin_nxt  = vmin_r;
    vmax_nxt  = vmax_r;
    vlast_nxt = vlast_r;
    vsec_nxt  = vsec_r;
    if (vld_d_r) begin
      if (idx_d_r == '0) begin
        imin_nxt = '0;
        imax_nxt = '0;
        vmin_nxt = rd_data;
        vmax_nxt = rd_data;
      end else begin
        if (rd_data < vmin_r) begin
          imin_nxt = idx_d_r;
          vmin_nxt = rd_data;
        end
        if (rd_data >= vmax_r) begin
          imax_nxt = idx_d_r;
          vmax_nxt = rd_data;
        end
      end
      if (idx_d_r == last_idx) begin
        vlast_nxt = rd_data;
      end
      if (idx_d_r == sec_idx) begin
        vsec_nxt = rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else begin
      vld_d_r <= vld_d_nxt;
    end
    idx_d_r <= idx_d_nxt;
    imin_r  <= imin_nxt;
    imax_r  <= imax_nxt;
    vmin_r  <= vmin_nxt;
    vmax_r  <= vmax_nxt;
    vlast_r <= vlast_nxt;
    vsec_r  <= vsec_nxt;
  end

  always_comb begin
    res.done  = vld_d_r && (idx_d_r == last_idx);
    res.imin  = imin_r;
    res.imax  = imax_r;
    res.vmin  = vmin_r;
    res.vmax  = vmax_r;
    res.vlast = vlast_r;
    res.vsec  = vsec_r;
  end

endmodule

@@ sv/minmax_pop_accumulator_top.sv @@
// Top level: store control, day-end removal of max and min, result register.
`timescale 1ns / 1ps
// Values live in a 1024 x 20 RAM with one write and one read port. A word
// without last_of_day only inserts: a value writes at the fill count, or is
// dropped and flagged when the store is full. A word with last_of_day also
// starts a scan, if at least two entries are stored, that reads every entry
// once through the read port; in_ready stays low until the result is loaded
// into the output register. Max and min are removed by moving tail entries
// into their slots. The result sits in an output register, so the next word
// is taken while it waits. The store needs no clearing after reset; ending a
// case resets only the count and total.
module minmax_pop_accumulator_top import mpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_has_value,
  input  logic [BILL_W-1:0]  in_bill_value,
  input  logic               in_last_of_day,
  input  logic               in_last_of_case,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [GAIN_W-1:0]  out_day_gain,
  output logic [TOTAL_W-1:0] out_running_total,
  output logic               out_case_done,
  output logic               out_underflow,
  output logic               out_overflow
);

  mpa_state_t state_r, state_nxt;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0]    total_r, total_nxt;
  logic                  drop_r, drop_nxt;
  logic                  case_r, case_nxt;
  logic                  under_r, under_nxt;
  logic [VALUE_BITS-1:0] gain_r, gain_nxt;
  logic [ADDR_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                  iss_r, iss_nxt;

  logic                  ov_r, ov_nxt;
  logic [GAIN_W-1:0]     og_r, og_nxt;
  logic [TOTAL_W-1:0]    ot_r, ot_nxt;
  logic                  oc_r, oc_nxt;
  logic                  ou_r, ou_nxt;
  logic                  oo_r, oo_nxt;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic                  re;
  logic [VALUE_BITS-1:0] rdata;

  mpa_scan_req_t         scan_req;
  mpa_scan_res_t         scan_res;
  logic [ADDR_W-1:0]     last_idx;

  logic                  accept;
  logic                  full;
  logic [CNT_W-1:0]      cnt_ins;
  logic [VALUE_BITS-1:0] ins_val;
  logic                  out_free;
  logic [ADDR_W-1:0]     imax_eff;
  logic [ADDR_W-1:0]     hi_idx;
  logic [ADDR_W-1:0]     lo_idx;
  logic [TOTAL_W:0]      sum;
  logic [TOTAL_W-1:0]    total_new;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign cnt_ins  = (in_has_value && !full) ? cnt_r + CNT_W'(1) : cnt_r;
  assign ins_val  = VALUE_BITS'(in_bill_value);
  assign out_free = !ov_r || out_ready;
  assign last_idx = ADDR_W'(cnt_r - CNT_W'(1));
  assign imax_eff = (scan_res.imin == scan_res.imax) ? last_idx : scan_res.imax;
  assign hi_idx   = (scan_res.imin > imax_eff) ? scan_res.imin : imax_eff;
  assign lo_idx   = (scan_res.imin > imax_eff) ? imax_eff : scan_res.imin;
  assign sum      = {1'b0, total_r} + (TOTAL_W + 1)'(gain_r);
  assign total_new = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  assign scan_req.issue = (state_r == ST_SCAN) && iss_r;
  assign scan_req.idx   = rd_idx_r;
  assign re             = scan_req.issue;

  mpa_ram #(
    .DEPTH  (CAPACITY),
    .DATA_W (VALUE_BITS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_idx_r),
    .rdata (rdata)
  );

  mpa_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (scan_req),
    .rd_data  (rdata),
    .last_idx (last_idx),
    .res      (scan_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_last_of_day) begin
          state_nxt = (cnt_ins >= CNT_W'(2)) ? ST_SCAN : ST_RES;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt = ST_WR_HI;
        end
      end
      ST_WR_HI: state_nxt = ST_WR_LO;
      ST_WR_LO: state_nxt = ST_RES;
      ST_RES: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    drop_nxt   = drop_r;
    case_nxt   = case_r;
    under_nxt  = under_r;
    gain_nxt   = gain_r;
    rd_idx_nxt = rd_idx_r;
    iss_nxt    = iss_r;
    ov_nxt     = ov_r && !out_ready;
    og_nxt     = og_r;
    ot_nxt     = ot_r;
    oc_nxt     = oc_r;
    ou_nxt     = ou_r;
    oo_nxt     = oo_r;
    we         = 1'b0;
    waddr      = ADDR_W'(cnt_r);
    wdata      = ins_val;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_has_value) begin
            if (full) begin
              drop_nxt = 1'b1;
            end else begin
              we      = 1'b1;
              cnt_nxt = cnt_ins;
            end
          end
          if (in_last_of_day) begin
            case_nxt   = in_last_of_case;
            rd_idx_nxt = '0;
            iss_nxt    = 1'b1;
            gain_nxt   = '0;
            under_nxt  = (cnt_ins < CNT_W'(2));
            if (cnt_ins < CNT_W'(2)) begin
              cnt_nxt = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        if (iss_r) begin
          rd_idx_nxt = rd_idx_r + ADDR_W'(1);
          if (rd_idx_r == last_idx) begin
            iss_nxt = 1'b0;
          end
        end
      end
      ST_WR_HI: begin
        we       = 1'b1;
        waddr    = hi_idx;
        wdata    = scan_res.vlast;
        gain_nxt = scan_res.vmax - scan_res.vmin;
      end
      ST_WR_LO: begin
        we      = 1'b1;
        waddr   = lo_idx;
        wdata   = (hi_idx == ADDR_W'(cnt_r - CNT_W'(2))) ? scan_res.vlast : scan_res.vsec;
        cnt_nxt = cnt_r - CNT_W'(2);
      end
      ST_RES: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          og_nxt    = GAIN_W'(gain_r);
          ot_nxt    = total_new;
          oc_nxt    = case_r;
          ou_nxt    = under_r;
          oo_nxt    = drop_r;
          drop_nxt  = 1'b0;
          total_nxt = case_r ? '0 : total_new;
          if (case_r) begin
            cnt_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      total_r <= '0;
      drop_r  <= 1'b0;
      iss_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      drop_r  <= drop_nxt;
      iss_r   <= iss_nxt;
      ov_r    <= ov_nxt;
    end
    case_r   <= case_nxt;
    under_r  <= under_nxt;
    gain_r   <= gain_nxt;
    rd_idx_r <= rd_idx_nxt;
    og_r     <= og_nxt;
    ot_r     <= ot_nxt;
    oc_r     <= oc_nxt;
    ou_r     <= ou_nxt;
    oo_r     <= oo_nxt;
  end

  assign out_valid         = ov_r;
  assign out_day_gain      = og_r;
  assign out_running_total = ot_r;
  assign out_case_done     = oc_r;
  assign out_underflow     = ou_r;
  assign out_overflow      = oo_r;

endmodule
